@@ hw/rtl/arcdda_pkg.sv @@
package arcdda_pkg;

  localparam int FRAME_W = 32;
  localparam int RATE_W = 16;
  localparam int BYTES_W = 17;
  localparam int SRC_IDX_W = 15;
  localparam int OUT_IDX_W = 18;
  localparam int DIVISOR_W = OUT_IDX_W + 1;
  localparam int PROD_W = RATE_W + BYTES_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = BYTES_W;

  localparam int FRACTION_BITS_DEFAULT = 18;
  localparam int MAX_RESULTS = 32;
  localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [OUT_IDX_W-1:0] TF_MAX = {OUT_IDX_W{1'b1}};

  localparam logic [RATE_W-1:0] SOURCE_RATE_RESET = RATE_W'(8000);
  localparam logic [RATE_W-1:0] TARGET_RATE_RESET = RATE_W'(8000);
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = BYTES_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    MODE_EQUAL,
    MODE_DOWN,
    MODE_UP
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTES_GO,
    ST_BYTES_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_DISPATCH,
    ST_EQUAL,
    ST_DOWN,
    ST_UP_PREV,
    ST_UP_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0]  source_rate;
    logic [RATE_W-1:0]  target_rate;
    logic [BYTES_W-1:0] block_bytes;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               run_last;
    logic               block_end;
  } res_t;

  // Width of the shared divider: wide enough for the byte-count product and
  // for the scaled frame counts of the step division.
  function automatic int div_width(input int fraction_bits);
    int w;
    w = fraction_bits + OUT_IDX_W + 2;
    if (w < PROD_W) begin
      w = PROD_W;
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/arcdda_if.sv @@
interface arcdda_in_if import arcdda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] in_frame;

  modport source (output valid, output in_frame, input ready);
  modport sink (input valid, input in_frame, output ready);
endinterface

interface arcdda_out_if import arcdda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] out_frame;
  logic               run_last;
  logic               block_end;

  modport source (output valid, output out_frame, output run_last, output block_end,
                  input ready);
  modport sink (input valid, input out_frame, input run_last, input block_end,
                output ready);
endinterface

@@ hw/rtl/audio_rate_converter_dda_unit.sv @@
// Nearest-neighbor sample rate converter for blocks of packed stereo frames.
// Frames enter on the frames channel, one request per 32-bit frame, and a block
// is block_bytes/4 frames long. Each request yields zero or more requests on
// the resampled channel, at most 32; run_last marks the last of them and
// block_end marks output frame number target_frames-1 of the block.
// The three registers are written through cfg_we/cfg_index/cfg_data and
// are sampled in ST_BYTES_GO, after the first frame of a block is taken.
// The first frame of a block also runs the byte-count division and, unless the
// rates are equal or a downsampled block has no output due, the step division
// on the shared restoring divider, one quotient bit per cycle; the divider is
// DW = max(33, FRACTION_BITS+20) bits wide. frames.ready is high only while the
// sequencer is idle, so one frame is in flight at a time.
// Results pass through a one-entry output register; when the receiver stalls,
// the sequencer waits on it and no result is lost.
// Reset (synchronous, active high) returns the registers to 8000 Hz, 8000 Hz
// and 4096 bytes, clears the output register and starts a new block with the
// next frame.
module audio_rate_converter_dda_unit import arcdda_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  arcdda_in_if.sink             frames,
  arcdda_out_if.source          resampled
);

  localparam int DW = div_width(FRACTION_BITS);

  cfg_t cfg;
  res_t result;
  res_t out_q;
  logic out_valid;
  logic out_free;
  logic emit;
  logic div_start;
  logic div_done;
  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_quotient;
  logic [DIVISOR_W-1:0] div_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_rate <= SOURCE_RATE_RESET;
      cfg.target_rate <= TARGET_RATE_RESET;
      cfg.block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_RATE: cfg.source_rate <= cfg_data[RATE_W-1:0];
        REG_TARGET_RATE: cfg.target_rate <= cfg_data[RATE_W-1:0];
        REG_BLOCK_BYTES: cfg.block_bytes <= cfg_data[BYTES_W-1:0];
        default: cfg <= cfg;
      endcase
    end
  end

  assign out_free = !out_valid || resampled.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (resampled.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign resampled.valid = out_valid;
  assign resampled.out_frame = out_q.frame;
  assign resampled.run_last = out_q.run_last;
  assign resampled.block_end = out_q.block_end;

  arcdda_div #(
    .DW(DW),
    .DVW(DIVISOR_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .done(div_done),
    .quotient(div_quotient)
  );

  arcdda_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(frames.valid),
    .in_frame(frames.in_frame),
    .in_ready(frames.ready),
    .out_free(out_free),
    .emit(emit),
    .result(result),
    .div_start(div_start),
    .div_dividend(div_dividend),
    .div_divisor(div_divisor),
    .div_done(div_done),
    .div_quotient(div_quotient)
  );

`ifndef NO_ASSERTIONS
  // A new result never lands on one the receiver has not taken.
  assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || resampled.ready))
    else $error("result register overwritten");

  // Taking a frame makes the sequencer busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (frames.valid && frames.ready) |=> !frames.ready)
    else $error("frame accepted while busy");

  // The final frame of a block is always the last result of its request.
  assert property (@(posedge clk) disable iff (rst)
    (resampled.valid && resampled.block_end) |-> resampled.run_last)
    else $error("block end without run end");
`endif

endmodule

@@ hw/rtl/arcdda_div.sv @@
module arcdda_div import arcdda_pkg::*; #(
  parameter int DW = PROD_W,
  parameter int DVW = DIVISOR_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DW-1:0]  quotient
);

  localparam int CW = $clog2(DW + 1);

  logic           busy;
  logic [CW-1:0]  count;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] div_q;
  logic [DW-1:0]  quo;
  logic [DVW:0]   shifted;
  logic           fits;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem, quo[DW-1]};
  assign fits = shifted >= {1'b0, div_q};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      div_q <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DVW'(shifted - {1'b0, div_q});
      end else begin
        rem <= shifted[DVW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/arcdda_ctrl.sv @@
module arcdda_ctrl import arcdda_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfg_t                                   cfg,
  input  logic                                   in_valid,
  input  logic [FRAME_W-1:0]                     in_frame,
  output logic                                   in_ready,
  input  logic                                   out_free,
  output logic                                   emit,
  output res_t                                   result,
  output logic                                   div_start,
  output logic [div_width(FRACTION_BITS)-1:0]    div_dividend,
  output logic [DIVISOR_W-1:0]                   div_divisor,
  input  logic                                   div_done,
  input  logic [div_width(FRACTION_BITS)-1:0]    div_quotient
);

  localparam int DW = div_width(FRACTION_BITS);
  localparam int PW = DW - FRACTION_BITS;
  localparam int SI1_W = SRC_IDX_W + 1;
  localparam int OI1_W = OUT_IDX_W + 1;
  localparam logic [DW-1:0] ACC_INIT =
    DW'(((64'd1 << FRACTION_BITS) - 64'd1) >> 1);

  state_t state, state_next;
  mode_t  mode;

  logic [FRAME_W-1:0]   frame_q;
  logic [FRAME_W-1:0]   prev_frame;
  logic [SRC_IDX_W-1:0] src_idx;
  logic [SRC_IDX_W-1:0] src_frames;
  logic [OUT_IDX_W-1:0] out_idx;
  logic [OUT_IDX_W-1:0] target_frames;
  logic [OUT_IDX_W-1:0] fill_to;
  logic [DW-1:0]        acc;
  logic [DW-1:0]        step;
  logic [COUNT_W-1:0]   n_out;

  logic [PROD_W-1:0]    product;
  logic [DIVISOR_W-1:0] src_divisor;
  logic [DW:0]          bytes_up;
  logic [DW-2:0]        quarter;
  logic [OUT_IDX_W-1:0] tc_calc;
  logic [SRC_IDX_W-1:0] sc_calc;
  mode_t                mode_calc;
  logic                 need_div;
  logic [DW-1:0]        step_dividend;
  logic [DIVISOR_W-1:0] step_divisor;

  logic [DW-1:0]        acc_sum;
  logic [PW-1:0]        acc_pos;
  logic [PW-1:0]        sum_pos;
  logic [PW-1:0]        si_ext;
  logic [OI1_W-1:0]     oi_inc;
  logic                 last;
  logic                 oi_lt_tc;
  logic                 oi_lt_fill;
  logic                 more_after;
  logic                 more_fill;
  logic                 capped;
  logic                 near_cap;
  logic                 down_cond;
  logic                 down_next;

  // Block-start arithmetic.
  assign product = PROD_W'(cfg.target_rate) * PROD_W'(cfg.block_bytes);
  assign src_divisor = (cfg.source_rate == '0) ? DIVISOR_W'(1)
                                                : DIVISOR_W'(cfg.source_rate);
  assign sc_calc = (cfg.block_bytes[BYTES_W-1:2] == '0) ? SRC_IDX_W'(1)
                                                         : cfg.block_bytes[BYTES_W-1:2];
  assign bytes_up = {1'b0, div_quotient} + (DW+1)'(3);
  assign quarter = bytes_up[DW:2];
  assign tc_calc = (quarter > (DW-1)'(TF_MAX)) ? TF_MAX : quarter[OUT_IDX_W-1:0];

  always_comb begin
    if (cfg.target_rate < cfg.source_rate) begin
      mode_calc = MODE_DOWN;
    end else if (cfg.target_rate > cfg.source_rate) begin
      mode_calc = MODE_UP;
    end else begin
      mode_calc = MODE_EQUAL;
    end
  end

  always_comb begin
    if (mode == MODE_DOWN) begin
      step_dividend = (DW'(src_frames) << (FRACTION_BITS + 1)) + DW'(target_frames);
      step_divisor = {target_frames, 1'b0};
      need_div = (target_frames != '0);
    end else begin
      step_dividend = (DW'(target_frames) << (FRACTION_BITS + 1)) + DW'(src_frames);
      step_divisor = DIVISOR_W'({src_frames, 1'b0});
      need_div = (mode == MODE_UP);
    end
  end

  // Per-output conditions.
  assign acc_sum = acc + step;
  assign acc_pos = acc[DW-1:FRACTION_BITS];
  assign sum_pos = acc_sum[DW-1:FRACTION_BITS];
  assign si_ext = PW'(src_idx);
  assign oi_inc = {1'b0, out_idx} + OI1_W'(1);
  assign last = ({1'b0, src_idx} + SI1_W'(1)) >= {1'b0, src_frames};
  assign oi_lt_tc = out_idx < target_frames;
  assign oi_lt_fill = out_idx < fill_to;
  assign more_after = oi_inc < {1'b0, target_frames};
  assign more_fill = oi_inc < {1'b0, fill_to};
  assign capped = n_out == COUNT_W'(MAX_RESULTS);
  assign near_cap = n_out == COUNT_W'(MAX_RESULTS - 1);
  assign down_cond = oi_lt_tc && (last || acc_pos <= si_ext);
  assign down_next = more_after && (last || sum_pos <= si_ext);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (src_idx == '0) ? ST_BYTES_GO : ST_DISPATCH;
        end
      end
      ST_BYTES_GO: state_next = ST_BYTES_WAIT;
      ST_BYTES_WAIT: begin
        if (div_done) begin
          state_next = ST_STEP_GO;
        end
      end
      ST_STEP_GO: state_next = need_div ? ST_STEP_WAIT : ST_DISPATCH;
      ST_STEP_WAIT: begin
        if (div_done) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (mode)
          MODE_EQUAL: state_next = ST_EQUAL;
          MODE_DOWN:  state_next = ST_DOWN;
          MODE_UP:    state_next = ST_UP_PREV;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_EQUAL: begin
        if (!oi_lt_tc || out_free) begin
          state_next = ST_DONE;
        end
      end
      ST_DOWN: begin
        if (!down_cond) begin
          state_next = ST_DONE;
        end
      end
      ST_UP_PREV: begin
        if (!oi_lt_fill) begin
          state_next = last ? ST_UP_LAST : ST_DONE;
        end
      end
      ST_UP_LAST: begin
        if (!oi_lt_tc) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    emit = 1'b0;
    result.frame = frame_q;
    result.run_last = 1'b1;
    result.block_end = (oi_inc == {1'b0, target_frames});
    div_start = 1'b0;
    div_dividend = DW'(product);
    div_divisor = src_divisor;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_BYTES_GO: div_start = 1'b1;
      ST_STEP_GO: begin
        div_start = need_div;
        div_dividend = step_dividend;
        div_divisor = step_divisor;
      end
      ST_EQUAL: emit = oi_lt_tc && out_free;
      ST_DOWN: begin
        emit = down_cond && !capped && out_free;
        result.run_last = near_cap || !down_next;
      end
      ST_UP_PREV: begin
        emit = oi_lt_fill && !capped && out_free;
        result.frame = prev_frame;
        result.run_last = near_cap || (!more_fill && !(last && more_after));
      end
      ST_UP_LAST: begin
        emit = oi_lt_tc && !capped && out_free;
        result.run_last = near_cap || !more_after;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      src_idx <= '0;
      prev_frame <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE) begin
        prev_frame <= frame_q;
        src_idx <= last ? '0 : src_idx + SRC_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      n_out <= n_out + COUNT_W'(1);
    end
    case (state)
      ST_IDLE: begin
        frame_q <= in_frame;
        n_out <= '0;
      end
      ST_BYTES_GO: begin
        src_frames <= sc_calc;
        mode <= mode_calc;
      end
      ST_BYTES_WAIT: begin
        if (div_done) begin
          target_frames <= (mode == MODE_EQUAL) ? OUT_IDX_W'(src_frames) : tc_calc;
        end
      end
      ST_STEP_GO: begin
        if (!need_div) begin
          step <= '0;
        end
        acc <= ACC_INIT;
        out_idx <= '0;
      end
      ST_STEP_WAIT: begin
        if (div_done) begin
          step <= div_quotient;
        end
      end
      ST_DISPATCH: begin
        fill_to <= (acc_pos > PW'(target_frames)) ? target_frames
                                                  : acc_pos[OUT_IDX_W-1:0];
      end
      ST_EQUAL: begin
        if (emit) begin
          out_idx <= oi_inc[OUT_IDX_W-1:0];
        end
      end
      ST_DOWN: begin
        if (down_cond && (capped || out_free)) begin
          // Past the result limit on the last frame, the position no longer matters.
          if (capped && last) begin
            out_idx <= target_frames;
          end else begin
            acc <= acc_sum;
            out_idx <= oi_inc[OUT_IDX_W-1:0];
          end
        end
      end
      ST_UP_PREV: begin
        if (oi_lt_fill) begin
          if (capped) begin
            out_idx <= fill_to;
          end else if (out_free) begin
            out_idx <= oi_inc[OUT_IDX_W-1:0];
          end
        end else begin
          acc <= acc_sum;
        end
      end
      ST_UP_LAST: begin
        if (oi_lt_tc) begin
          if (capped) begin
            out_idx <= target_frames;
          end else if (out_free) begin
            out_idx <= oi_inc[OUT_IDX_W-1:0];
          end
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
